// ----- rtl/length_prefixed_request_deframer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed request deframer
// Concurrent checks on clk_i with reset rst_ni; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_REQUEST_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_REQUEST_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define LPRD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lprd: assertion failed");
// Checks that a condition never occurs outside reset.
`define LPRD_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("lprd: forbidden condition seen");
`else
`define LPRD_ASSERT(label, prop)
`define LPRD_ASSERT_NEVER(label, cond)
`endif

`endif

// ----- rtl/lprd_pkg.sv -----
// ----------------------------------------------------------------------------
// lprd_pkg
// Shared constants, result codes and types of the request deframer.
// ----------------------------------------------------------------------------
package lprd_pkg;

  // Width of the frame byte counters.
  localparam int unsigned LENGTH_BITS = 32;

  // Width of the string index and its saturation value.
  localparam int unsigned INDEX_W = 25;
  localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

  // Reset value of the length limit register (32 MiB).
  localparam logic [31:0] MAX_LEN_RESET = 32'(32 << 20);

  // Byte roles.
  localparam logic [2:0] ROLE_FRAME_LEN = 3'd0;
  localparam logic [2:0] ROLE_COUNT     = 3'd1;
  localparam logic [2:0] ROLE_STR_LEN   = 3'd2;
  localparam logic [2:0] ROLE_STR_DATA  = 3'd3;
  localparam logic [2:0] ROLE_DISCARD   = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_TOOLONG = 2'd2;
  localparam logic [1:0] ST_CLOSED  = 2'd3;

  // One tagged byte.
  typedef struct packed {
    logic [7:0]         byte_out;
    logic [2:0]         byte_role;
    logic [INDEX_W-1:0] string_index;
    logic               string_done;
    logic               request_done;
    logic [1:0]         status;
  } lprd_result_t;

endpackage

// ----- rtl/lprd_parser.sv -----
// ----------------------------------------------------------------------------
// lprd_parser
// Framing state of the deframer. Tags one byte per step and advances the
// frame, string and field counters.
// ----------------------------------------------------------------------------
`include "length_prefixed_request_deframer_assert.svh"

module lprd_parser
  import lprd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   data_byte_i,
  input  logic [31:0]  max_len_i,
  output lprd_result_t result_o
);

  localparam logic [1:0] PH_FRAME_LEN = 2'd0;
  localparam logic [1:0] PH_COUNT     = 2'd1;
  localparam logic [1:0] PH_STR_LEN   = 2'd2;
  localparam logic [1:0] PH_STR_DATA  = 2'd3;

  logic [1:0]             phase_q, phase_d;
  logic [1:0]             cnt_q, cnt_d;
  logic [23:0]            field_q, field_d;
  logic [LENGTH_BITS-1:0] frame_left_q, frame_left_d;
  logic [31:0]            strings_q, strings_d;
  logic [INDEX_W-1:0]     cur_str_q, cur_str_d;
  logic [LENGTH_BITS-1:0] str_left_q, str_left_d;
  logic                   closed_q, closed_d;

  logic [23:0]            field_next;
  logic [31:0]            field_val;
  logic                   field_done;
  logic [LENGTH_BITS-1:0] frame_dec;
  logic                   bad, toolong, whole, str_end;

  // Little-endian field gathering: three bytes are held, the fourth comes live.
  always_comb begin
    field_next = field_q;
    case (cnt_q)
      2'd0:    field_next[7:0]   = data_byte_i;
      2'd1:    field_next[15:8]  = data_byte_i;
      2'd2:    field_next[23:16] = data_byte_i;
      default: field_next        = field_q;
    endcase
  end

  assign field_val  = {data_byte_i, field_q};
  assign field_done = (cnt_q == 2'd3);
  assign frame_dec  = frame_left_q - 1'b1;

  // Tagging and next state for one byte.
  always_comb begin
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    field_d      = field_q;
    frame_left_d = frame_left_q;
    strings_d    = strings_q;
    cur_str_d    = cur_str_q;
    str_left_d   = str_left_q;
    closed_d     = closed_q;
    bad          = 1'b0;
    toolong      = 1'b0;
    whole        = 1'b0;
    str_end      = 1'b0;

    result_o.byte_out     = data_byte_i;
    result_o.byte_role    = ROLE_DISCARD;
    result_o.string_index = '0;
    result_o.string_done  = 1'b0;
    result_o.request_done = 1'b0;
    result_o.status       = ST_OK;

    if (closed_q) begin
      result_o.status = ST_CLOSED;
    end else begin
      // Field gathering applies to every phase but string data.
      if (phase_q != PH_STR_DATA) begin
        if (field_done) begin
          cnt_d   = 2'd0;
          field_d = '0;
        end else begin
          cnt_d   = cnt_q + 2'd1;
          field_d = field_next;
        end
      end

      case (phase_q)
        PH_FRAME_LEN: begin
          result_o.byte_role = ROLE_FRAME_LEN;
          if (field_done) begin
            if ((field_val > max_len_i) ||
                ((33'(field_val) >> LENGTH_BITS) != 33'd0)) begin
              toolong = 1'b1;
            end else if (field_val == 32'd0) begin
              bad = 1'b1;
            end else begin
              frame_left_d = LENGTH_BITS'(field_val);
              phase_d      = PH_COUNT;
            end
          end
        end
        PH_COUNT: begin
          result_o.byte_role = ROLE_COUNT;
          frame_left_d       = frame_dec;
          if (field_done) begin
            if (field_val > max_len_i) begin
              bad = 1'b1;
            end else begin
              strings_d = field_val;
              if (field_val == 32'd0) begin
                whole = 1'b1;
              end else begin
                phase_d = PH_STR_LEN;
              end
            end
          end
        end
        PH_STR_LEN: begin
          result_o.byte_role    = ROLE_STR_LEN;
          result_o.string_index = cur_str_q;
          frame_left_d          = frame_dec;
          if (field_done) begin
            if (field_val > 32'(frame_dec)) begin
              bad = 1'b1;
            end else if (field_val == 32'd0) begin
              str_end = 1'b1;
            end else begin
              str_left_d = LENGTH_BITS'(field_val);
              phase_d    = PH_STR_DATA;
            end
          end
        end
        default: begin
          result_o.byte_role    = ROLE_STR_DATA;
          result_o.string_index = cur_str_q;
          frame_left_d          = frame_dec;
          str_left_d            = str_left_q - 1'b1;
          str_end               = (str_left_q == LENGTH_BITS'(1));
        end
      endcase

      // A string completes: move to the next one or finish the request.
      if (str_end) begin
        result_o.string_done = 1'b1;
        strings_d            = strings_q - 32'd1;
        if (cur_str_q != INDEX_MAX) begin
          cur_str_d = cur_str_q + 1'b1;
        end
        if (strings_q == 32'd1) begin
          whole = 1'b1;
        end else begin
          phase_d = PH_STR_LEN;
        end
      end

      // Frame accounting against the bytes still left in the frame.
      if (!bad && !toolong) begin
        if (whole) begin
          if (frame_left_d != '0) begin
            bad = 1'b1;
          end else begin
            result_o.request_done = 1'b1;
            phase_d               = PH_FRAME_LEN;
            cur_str_d             = '0;
            cnt_d                 = 2'd0;
            field_d               = '0;
          end
        end else if (phase_d != PH_FRAME_LEN && frame_left_d == '0) begin
          bad = 1'b1;
        end
      end

      // A framing fault closes the connection for good.
      if (bad || toolong) begin
        closed_d              = 1'b1;
        result_o.status       = toolong ? ST_TOOLONG : ST_BAD;
        result_o.string_done  = 1'b0;
        result_o.request_done = 1'b0;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_FRAME_LEN;
      cnt_q        <= 2'd0;
      field_q      <= '0;
      frame_left_q <= '0;
      strings_q    <= '0;
      cur_str_q    <= '0;
      str_left_q   <= '0;
      closed_q     <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      cnt_q        <= cnt_d;
      field_q      <= field_d;
      frame_left_q <= frame_left_d;
      strings_q    <= strings_d;
      cur_str_q    <= cur_str_d;
      str_left_q   <= str_left_d;
      closed_q     <= closed_d;
    end
  end

  // Once closed, the parser never reopens without reset.
  `LPRD_ASSERT(a_closed_sticky, closed_q |=> closed_q)
  // String data is only ever expected while data bytes remain.
  `LPRD_ASSERT(a_data_left, !closed_q && phase_q == PH_STR_DATA |-> str_left_q != '0)
  // Inside a frame, at least one frame byte is always still due.
  `LPRD_ASSERT(a_frame_live, !closed_q && phase_q != PH_FRAME_LEN |-> frame_left_q != '0)

endmodule

// ----- rtl/length_prefixed_request_deframer.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_request_deframer
// Tags a byte stream of length-prefixed requests with role, string index and
// completion flags, and closes the connection on a framing fault.
// ----------------------------------------------------------------------------
// The block accepts one byte per clock cycle while the output is not stalled
// and returns one tagged byte for each, in order. A byte passes an input
// register, combinational parse logic that updates the frame, string and
// field counters, and a result register, from which its result is offered;
// the parse stage sets the rate of one byte per cycle. Stalls on the
// output back up into the input without losing bytes. The length limit
// register may be written only while no byte is in flight. After a fault the
// status reads closed until reset.
`include "length_prefixed_request_deframer_assert.svh"

module length_prefixed_request_deframer
  import lprd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_max_message_length_i,
  // Byte input channel.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  // Tagged byte output channel.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         byte_out_o,
  output logic [2:0]         byte_role_o,
  output logic [INDEX_W-1:0] string_index_o,
  output logic               string_done_o,
  output logic               request_done_o,
  output logic [1:0]         status_o
);

  logic [31:0]  max_len_val_q;
  logic         s1_valid_q;
  logic [7:0]   s1_byte_q;
  logic         out_valid_q;
  lprd_result_t res_d, res_q;
  logic         advance;

  // Configuration is always accepted.
  assign cfg_ready_o = 1'b1;

  // The parse stage moves when a byte waits and the result slot is free.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  // Length limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_val_q <= MAX_LEN_RESET;
    end else if (cfg_valid_i) begin
      max_len_val_q <= cfg_max_message_length_i;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= data_byte_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Framing state and byte tagging.
  lprd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .data_byte_i (s1_byte_q),
    .max_len_i   (max_len_val_q),
    .result_o    (res_d)
  );

  assign out_valid_o    = out_valid_q;
  assign byte_out_o     = res_q.byte_out;
  assign byte_role_o    = res_q.byte_role;
  assign string_index_o = res_q.string_index;
  assign string_done_o  = res_q.string_done;
  assign request_done_o = res_q.request_done;
  assign status_o       = res_q.status;

  // A closed connection only discards bytes.
  `LPRD_ASSERT(a_closed_discard, out_valid_o && status_o == ST_CLOSED |-> byte_role_o == ROLE_DISCARD)
  // A closed connection reports no string index.
  `LPRD_ASSERT(a_closed_index, out_valid_o && status_o == ST_CLOSED |-> string_index_o == '0)
  // A finished request is never reported together with a fault.
  `LPRD_ASSERT(a_done_ok, out_valid_o && request_done_o |-> status_o == ST_OK)
  // Roles beyond discarded never leave the block.
  `LPRD_ASSERT_NEVER(a_role_range, out_valid_o && byte_role_o > ROLE_DISCARD)
  // The limit register is written only by the configuration channel.
  `LPRD_ASSERT(a_cfg_hold, !cfg_valid_i |=> $stable(max_len_val_q))

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench of the length-prefixed request deframer
// Drives byte streams of framed messages (directed, random and one final
// framing fault) with random gaps on both channels. A scoreboard predicts the
// tag of every byte and compares it with each tagged byte that comes out.
// ----------------------------------------------------------------------------
module testbench
  import lprd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_AFTER   = 400;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned MAX_REPORTS  = 10;

  // Kinds of framing fault that end the run.
  typedef enum int unsigned {
    FAULT_TOO_LONG,
    FAULT_COUNT_OVER,
    FAULT_EMPTY_FRAME,
    FAULT_STRING_OVERRUN,
    FAULT_FRAME_SHORT,
    FAULT_LEFTOVER
  } fault_kind_e;

  // Predicts the tag of each accepted byte and checks the tagged output.
  class tag_scoreboard;
    typedef enum logic [2:0] {
      AWAIT_FRAME_LEN,
      AWAIT_COUNT,
      AWAIT_STR_LEN,
      IN_STR_DATA
    } parse_phase_e;

    logic [31:0]        limit;
    parse_phase_e       phase;
    logic [1:0]         field_cnt;
    logic [31:0]        field_acc;
    logic [31:0]        frame_left;
    logic [31:0]        strings_left;
    logic [INDEX_W-1:0] cur_string;
    logic [31:0]        str_left;
    bit                 closed;
    lprd_result_t       expected_tags[$];
    int unsigned        failures;

    function new();
      limit        = MAX_LEN_RESET;
      phase        = AWAIT_FRAME_LEN;
      field_cnt    = '0;
      field_acc    = '0;
      frame_left   = '0;
      strings_left = '0;
      cur_string   = '0;
      str_left     = '0;
      closed       = 1'b0;
      failures     = 0;
    endfunction

    function void set_limit(logic [31:0] value);
      limit = value;
    endfunction

    function int unsigned pending();
      return expected_tags.size();
    endfunction

    // Collects one byte of a little-endian 32-bit field; true on the fourth.
    function bit take_field_byte(logic [7:0] b, output logic [31:0] word);
      field_acc = field_acc | (32'(b) << (8 * field_cnt));
      word = field_acc;
      if (field_cnt == 2'd3) begin
        field_acc = '0;
        field_cnt = '0;
        return 1'b1;
      end
      field_cnt = field_cnt + 2'd1;
      return 1'b0;
    endfunction

    // Works out the tag of an accepted byte and queues it.
    function void note_byte(logic [7:0] b);
      lprd_result_t r;
      logic [31:0]  word;
      bit           fault_bad;
      bit           fault_long;
      bit           whole;
      bit           str_end;
      r = '0;
      r.byte_out = b;
      r.byte_role = ROLE_DISCARD;
      r.status = ST_OK;
      fault_bad = 1'b0;
      fault_long = 1'b0;
      whole = 1'b0;
      str_end = 1'b0;
      if (closed) begin
        r.status = ST_CLOSED;
      end else begin
        case (phase)
          AWAIT_FRAME_LEN: begin
            r.byte_role = ROLE_FRAME_LEN;
            if (take_field_byte(b, word)) begin
              if (word > limit || {32'd0, word} > ((64'd1 << LENGTH_BITS) - 64'd1)) begin
                fault_long = 1'b1;
              end else if (word == 0) begin
                fault_bad = 1'b1;
              end else begin
                frame_left = word;
                phase = AWAIT_COUNT;
              end
            end
          end
          AWAIT_COUNT: begin
            r.byte_role = ROLE_COUNT;
            frame_left = frame_left - 1;
            if (take_field_byte(b, word)) begin
              if (word > limit) begin
                fault_bad = 1'b1;
              end else begin
                strings_left = word;
                if (word == 0) whole = 1'b1;
                else phase = AWAIT_STR_LEN;
              end
            end
          end
          AWAIT_STR_LEN: begin
            r.byte_role = ROLE_STR_LEN;
            r.string_index = cur_string;
            frame_left = frame_left - 1;
            if (take_field_byte(b, word)) begin
              if (word > frame_left) begin
                fault_bad = 1'b1;
              end else if (word == 0) begin
                str_end = 1'b1;
              end else begin
                str_left = word;
                phase = IN_STR_DATA;
              end
            end
          end
          default: begin
            r.byte_role = ROLE_STR_DATA;
            r.string_index = cur_string;
            frame_left = frame_left - 1;
            str_left = str_left - 1;
            if (str_left == 0) str_end = 1'b1;
          end
        endcase

        // A finished string moves on to the next one or ends the frame.
        if (str_end) begin
          r.string_done = 1'b1;
          strings_left = strings_left - 1;
          if (cur_string != INDEX_MAX) cur_string = cur_string + 1'b1;
          if (strings_left == 0) whole = 1'b1;
          else phase = AWAIT_STR_LEN;
        end

        // The frame must end exactly with its last string.
        if (!fault_bad && !fault_long) begin
          if (whole) begin
            if (frame_left != 0) begin
              fault_bad = 1'b1;
            end else begin
              r.request_done = 1'b1;
              phase = AWAIT_FRAME_LEN;
              cur_string = '0;
              field_cnt = '0;
              field_acc = '0;
            end
          end else if (phase != AWAIT_FRAME_LEN && frame_left == 0) begin
            fault_bad = 1'b1;
          end
        end

        if (fault_bad || fault_long) begin
          closed = 1'b1;
          r.status = fault_long ? ST_TOOLONG : ST_BAD;
          r.string_done = 1'b0;
          r.request_done = 1'b0;
        end
      end
      expected_tags.insert(expected_tags.size(), r);
    endfunction

    function void flag_failure(string why, lprd_result_t want, lprd_result_t got);
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("%0t %s: expected byte %02h role %0d index %0d sdone %0b rdone %0b st %0d",
                 $realtime, why, want.byte_out, want.byte_role, want.string_index,
                 want.string_done, want.request_done, want.status);
        $display("%0t %s: actual   byte %02h role %0d index %0d sdone %0b rdone %0b st %0d",
                 $realtime, why, got.byte_out, got.byte_role, got.string_index,
                 got.string_done, got.request_done, got.status);
      end
    endfunction

    // Compares one tagged byte with the oldest prediction.
    function void check_result(lprd_result_t got);
      lprd_result_t want;
      if (expected_tags.size() == 0) begin
        flag_failure("tag without a pending byte", '0, got);
        return;
      end
      want = expected_tags.pop_front();
      if (got.byte_out !== want.byte_out || got.byte_role !== want.byte_role ||
          got.string_index !== want.string_index ||
          got.string_done !== want.string_done ||
          got.request_done !== want.request_done || got.status !== want.status) begin
        flag_failure("tag mismatch", want, got);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [31:0]        cfg_max_message_length_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         data_byte_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [7:0]         byte_out_o;
  logic [2:0]         byte_role_o;
  logic [INDEX_W-1:0] string_index_o;
  logic               string_done_o;
  logic               request_done_o;
  logic [1:0]         status_o;

  tag_scoreboard sb = new();
  logic [7:0]    tx_bytes[$];
  logic [31:0]   limit_now = MAX_LEN_RESET;
  int unsigned   bytes_sent = 0;
  int unsigned   tx_calm = 0;
  int unsigned   cycle_count = 0;
  logic          long_hold = 1'b0;

  length_prefixed_request_deframer i_dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .cfg_max_message_length_i(cfg_max_message_length_i),
    .in_valid_i              (in_valid_i),
    .in_ready_o              (in_ready_o),
    .data_byte_i             (data_byte_i),
    .out_valid_o             (out_valid_o),
    .out_ready_i             (out_ready_i),
    .byte_out_o              (byte_out_o),
    .byte_role_o             (byte_role_o),
    .string_index_o          (string_index_o),
    .string_done_o           (string_done_o),
    .request_done_o          (request_done_o),
    .status_o                (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones, and now and then a calm stretch.
  function automatic int unsigned pick_gap(inout int unsigned calm_left);
    int unsigned roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Queues one byte at the end of the stream to send.
  function automatic void append_tx_byte(logic [7:0] b);
    tx_bytes.insert(tx_bytes.size(), b);
  endfunction

  // Adds one string length at the end of a list of lengths.
  function automatic void append_len(ref int unsigned q[$], input int unsigned v);
    q.insert(q.size(), v);
  endfunction

  function automatic void append_word(logic [31:0] w);
    for (int k = 0; k < 4; k++) append_tx_byte(w[8*k +: 8]);
  endfunction

  // Appends a frame with the given string lengths; the two offsets skew the
  // frame length and the string count away from what the strings need.
  function automatic void build_frame(int unsigned lens[$], int frame_extra,
                                      int count_extra);
    int unsigned total;
    total = 4;
    foreach (lens[i]) total += 4 + lens[i];
    append_word(32'(int'(total) + frame_extra));
    append_word(32'(int'(lens.size()) + count_extra));
    foreach (lens[i]) begin
      append_word(lens[i]);
      repeat (lens[i]) append_tx_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  // Picks a random well-formed frame that fits the current limit.
  function automatic void build_random_frame(int frame_extra, int count_extra);
    int unsigned     lens[$];
    int unsigned     n;
    int unsigned     len;
    longint unsigned total;
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    total = 4;
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) len = $urandom_range(50, 200);
      else if ($urandom_range(0, 4) == 0) len = 0;
      else len = $urandom_range(1, 12);
      append_len(lens, len);
      total += 4 + len;
    end
    while (total + longint'(frame_extra) > {32'd0, limit_now} && lens.size() > 0) begin
      total -= 4 + lens[$];
      void'(lens.pop_back());
    end
    build_frame(lens, frame_extra, count_extra);
  endfunction

  // Offers one byte request after a random gap and waits until it is taken.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = long_hold ? 0 : pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_stream();
    while (tx_bytes.size() > 0) send_byte(tx_bytes.pop_front());
  endtask

  // Stops offering and waits until every predicted tag has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_max_message_length_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_limit(value);
    limit_now = value;
  endtask

  task automatic send_random_frames(input int unsigned byte_goal);
    int unsigned target;
    target = bytes_sent + byte_goal;
    while (bytes_sent < target) begin
      build_random_frame(0, 0);
      send_stream();
    end
  endtask

  // Takes tagged bytes with random stalls and one long hold-off that makes
  // the block fill up and stall its input.
  initial begin : receiver
    lprd_result_t got;
    int unsigned  stall_left;
    int unsigned  hold_left;
    int unsigned  rx_calm;
    bit           hold_done;
    stall_left = 0;
    hold_left = 0;
    rx_calm = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.byte_out = byte_out_o;
        got.byte_role = byte_role_o;
        got.string_index = string_index_o;
        got.string_done = string_done_o;
        got.request_done = request_done_o;
        got.status = status_o;
        sb.check_result(got);
      end
      if (!hold_done && bytes_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        long_hold <= 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
        if (hold_left == 0) long_hold <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        stall_left = pick_gap(rx_calm);
        if (stall_left == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          stall_left--;
          out_ready_i <= 1'b0;
        end
      end
    end
  end

  // Ends a run that hangs.
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : stimulus
    int unsigned lens[$];
    fault_kind_e kind;
    logic [31:0] frame_len;
    logic [31:0] lim;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at the reset limit: zero count, empty strings,
    // extreme data bytes and one longer string.
    build_frame(lens, 0, 0);
    append_len(lens, 0);
    build_frame(lens, 0, 0);
    append_len(lens, 0);
    append_len(lens, 0);
    build_frame(lens, 0, 0);
    append_word(32'd10);
    append_word(32'd1);
    append_word(32'd2);
    append_tx_byte(8'h00);
    append_tx_byte(8'hFF);
    lens.delete();
    append_len(lens, 1);
    append_len(lens, 7);
    append_len(lens, 3);
    build_frame(lens, 0, 0);
    lens.delete();
    append_len(lens, 255);
    build_frame(lens, 0, 0);
    send_stream();

    // Largest limit; the long receiver hold-off falls in this phase.
    write_limit(32'hFFFF_FFFF);
    send_random_frames(550);

    // Tight limit with a frame exactly at the limit.
    write_limit(32'd24);
    lens.delete();
    append_len(lens, 6);
    append_len(lens, 6);
    build_frame(lens, 0, 0);
    send_stream();
    send_random_frames(250);

    write_limit(32'($urandom_range(40, 4096)));
    send_random_frames(700);

    // One framing fault closes the block for the rest of the run.
    kind = fault_kind_e'($urandom_range(0, 5));
    case (kind)
      FAULT_TOO_LONG: begin
        lim = ($urandom_range(0, 1) == 1) ? 32'd0 : 32'($urandom_range(4, 64));
        write_limit(lim);
        frame_len = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                : lim + 32'd1 + 32'($urandom_range(0, 1000));
        append_word(frame_len);
      end
      FAULT_COUNT_OVER: begin
        write_limit(32'd64);
        append_word(32'($urandom_range(4, 64)));
        append_word(($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF
                                                : 32'($urandom_range(65, 1000)));
      end
      FAULT_EMPTY_FRAME: begin
        build_random_frame(0, 0);
        append_word(32'd0);
      end
      FAULT_STRING_OVERRUN: begin
        write_limit(32'd64);
        frame_len = 32'($urandom_range(8, 64));
        append_word(frame_len);
        append_word(32'($urandom_range(1, 4)));
        append_word(($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                : frame_len - 32'd7 + 32'($urandom_range(0, 50)));
      end
      FAULT_FRAME_SHORT: begin
        if ($urandom_range(0, 1) == 1) begin
          append_word(32'($urandom_range(1, 3)));
          append_word($urandom());
        end else begin
          build_random_frame(0, 1);
        end
      end
      default: begin
        if ($urandom_range(0, 1) == 1) begin
          write_limit(32'hFFFF_FFFF);
          append_word(32'hFFFF_FFFF);
          append_word(32'd0);
        end else begin
          build_random_frame(int'($urandom_range(1, 8)), 0);
        end
      end
    endcase
    repeat (20) append_tx_byte(8'($urandom_range(0, 255)));
    send_stream();
    settle();

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lprd_pkg.sv
rtl/lprd_parser.sv
rtl/length_prefixed_request_deframer.sv
test/testbench.sv
